// File: design/qts_pkg.sv
// ----------------------------------------------------------------------------
// qts_pkg: shared types and constants for the quoted token splitter
// Beat layouts, the per-byte result bundle and the character classes.
// ----------------------------------------------------------------------------
package qts_pkg;

    // Special characters
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Results one source byte can produce at most
    localparam int unsigned MAX_RES = 3;
    localparam int unsigned RES_W   = $clog2(MAX_RES + 1);

    // Queue between front and back
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    // Input beat
    typedef struct packed {
        logic [7:0] in_char;
        logic       source_last;
    } src_beat_t;

    // Output beat
    typedef struct packed {
        logic [7:0] token_char;
        logic       token_last;
        logic       is_comment;
    } tok_beat_t;

    // All beats caused by one source byte, first one in res[0]
    typedef struct packed {
        logic [RES_W-1:0]          cnt;
        tok_beat_t [MAX_RES-1:0]   res;
    } bundle_t;

    // Scanner state
    typedef struct packed {
        logic       in_string;
        logic       in_comment;
        logic       bs_pend;
        logic       held_valid;
        logic [7:0] held_char;
    } scan_state_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic f_is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

// File: design/qts_front.sv
// ----------------------------------------------------------------------------
// qts_front: byte classifier
// Takes one source byte per cycle while the queue has room, updates the
// scanner state and pushes the byte's bundle of token beats into the queue.
// ----------------------------------------------------------------------------
module qts_front
    import qts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  src_beat_t src,
    input  q_status_t q_stat,
    output logic      push,
    output bundle_t   push_data
);

    typedef struct packed {
        scan_state_t st;
        bundle_t     bun;
    } work_t;

    scan_state_t st_reg;
    scan_state_t st_next;
    work_t       w;
    logic        consumed;
    logic        accept;

    // Add one beat to the bundle, tagged with the current comment flag
    function automatic work_t f_emit(input work_t wi, input logic [7:0] ch,
                                     input logic last);
        work_t wo;
        wo = wi;
        if (wo.bun.cnt < RES_W'(MAX_RES))
        begin
            wo.bun.res[wo.bun.cnt[1:0]].token_char = ch;
            wo.bun.res[wo.bun.cnt[1:0]].token_last = last;
            wo.bun.res[wo.bun.cnt[1:0]].is_comment = wo.st.in_comment;
            wo.bun.cnt = wo.bun.cnt + RES_W'(1);
        end
        return wo;
    endfunction

    // Push out the held character (not last) and hold the new one
    function automatic work_t f_append(input work_t wi, input logic [7:0] ch);
        work_t wo;
        wo = wi;
        if (wo.st.held_valid)
        begin
            wo = f_emit(wo, wo.st.held_char, 1'b1 ^ 1'b1);
        end
        wo.st.held_char  = ch;
        wo.st.held_valid = 1'b1;
        return wo;
    endfunction

    // Close the current token on the held character
    function automatic work_t f_end(input work_t wi);
        work_t wo;
        wo = wi;
        if (wo.st.held_valid)
        begin
            wo = f_emit(wo, wo.st.held_char, 1'b1);
        end
        wo.st.held_valid = 1'b0;
        wo.st.held_char  = 8'h00;
        return wo;
    endfunction

    assign src_stall = q_stat.full;
    assign accept    = src_valid && !q_stat.full;

    // Classify the byte and build its bundle
    always_comb
    begin
        w        = '0;
        w.st     = st_reg;
        consumed = 1'b0;

        if (w.st.in_comment)
        begin
            w        = f_append(w, src.in_char);
            consumed = 1'b1;
        end
        else if (w.st.bs_pend)
        begin
            w.st.bs_pend = 1'b0;
            if (src.in_char == CH_QUOTE)
            begin
                w        = f_append(w, CH_QUOTE);
                consumed = 1'b1;
            end
            else
            begin
                w = f_append(w, CH_BSLASH);
            end
        end

        if (!consumed)
        begin
            if (!w.st.in_string && f_is_blank(src.in_char))
            begin
                w = f_end(w);
            end
            else if (w.st.in_string && (src.in_char == CH_BSLASH))
            begin
                if (src.source_last)
                begin
                    w = f_append(w, src.in_char);
                end
                else
                begin
                    w.st.bs_pend = 1'b1;
                end
            end
            else if (!w.st.in_string && (src.in_char == CH_HASH))
            begin
                w = f_end(w);
                if (!src.source_last)
                begin
                    w.st.in_comment = 1'b1;
                    w = f_append(w, src.in_char);
                end
            end
            else if (src.in_char == CH_QUOTE)
            begin
                w.st.in_string = !w.st.in_string;
            end
            else
            begin
                w = f_append(w, src.in_char);
            end
        end

        // Final byte flushes the token and clears everything
        if (src.source_last)
        begin
            w    = f_end(w);
            w.st = '0;
        end

        st_next = accept ? w.st : st_reg;
    end

    assign push      = accept && (w.bun.cnt != '0);
    assign push_data = w.bun;

    // Scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    // An escape is only pending inside a string
    a_bs_in_string: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.bs_pend |-> (st_reg.in_string && !st_reg.in_comment))
        else $error("escape pending outside a string");

endmodule

// File: design/qts_queue.sv
// ----------------------------------------------------------------------------
// qts_queue: bundle queue
// Short first-in first-out store of result bundles between front and back.
// ----------------------------------------------------------------------------
module qts_queue
    import qts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  bundle_t   push_data,
    input  logic      pop,
    output bundle_t   pop_data,
    output q_status_t q_stat
);

    bundle_t         mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;
    logic [Q_CW-1:0] count_next;

    assign q_stat.full  = (count_reg == Q_CW'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_data     = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CW'(1);
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_stat.empty))
        else $error("pop from an empty queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[Q_AW-1:0])
        else $error("queue pointers disagree with fill level");

endmodule

// File: design/qts_back.sv
// ----------------------------------------------------------------------------
// qts_back: beat serialiser
// Takes one bundle at a time from the queue and sends its beats out one per
// cycle while tok_stall is low, from a registered shift stage.
// ----------------------------------------------------------------------------
module qts_back
    import qts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_stat,
    input  bundle_t   pop_data,
    output logic      pop,
    output logic      tok_valid,
    input  logic      tok_stall,
    output tok_beat_t tok
);

    bundle_t cur_reg;
    bundle_t cur_next;
    logic    take;
    logic    drained;

    assign tok_valid = (cur_reg.cnt != '0);
    assign tok       = cur_reg.res[0];
    assign take      = tok_valid && !tok_stall;
    // stage frees up this cycle
    assign drained   = !tok_valid || (take && (cur_reg.cnt == RES_W'(1)));
    assign pop       = drained && !q_stat.empty;

    // Load a new bundle or shift the current one along
    always_comb
    begin
        cur_next = cur_reg;
        if (pop)
        begin
            cur_next = pop_data;
        end
        else if (take)
        begin
            cur_next.res[0] = cur_reg.res[1];
            cur_next.res[1] = cur_reg.res[2];
            cur_next.cnt    = cur_reg.cnt - RES_W'(1);
        end
    end

    // Output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
        end
        else
        begin
            cur_reg <= cur_next;
        end
    end

endmodule

// File: design/quoted_token_splitter.sv
// ----------------------------------------------------------------------------
// quoted_token_splitter: splits source text into tokens
// Blank-separated tokens with quoted strings, escaped quotes and a trailing
// comment token; one character is held back to mark each token end.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Beat
//  src     | in        | src_valid/src_stall  | src_beat_t (in_char, source_last)
//  tok     | out       | tok_valid/tok_stall  | tok_beat_t (token_char,
//          |           |                      |   token_last, is_comment)
//
//  A source byte is taken every cycle while the four-entry bundle queue has
//  room. Each byte gives zero to three token beats; the output sends one
//  beat per cycle while tok_stall is low, so sustained throughput is one
//  byte per cycle as long as bytes average at most one beat. The first beat
//  of a byte is registered in the bundle queue and then in the output stage
//  before it is on tok. Reset clears scanner state, queue and output stage.
//  A stalled output fills the queue, after which src_stall rises.
// ----------------------------------------------------------------------------
module quoted_token_splitter
    import qts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  src_beat_t src,
    output logic      tok_valid,
    input  logic      tok_stall,
    output tok_beat_t tok
);

    q_status_t q_stat;
    logic      push;
    logic      pop;
    bundle_t   push_data;
    bundle_t   pop_data;

    qts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src       (src),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    qts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    qts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .pop_data  (pop_data),
        .pop       (pop),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok       (tok)
    );

endmodule

// File: tb/quoted_token_splitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_token_splitter_tb: self-checking bench for the quoted token splitter
// A short table of directed bytes, then randomly built sources of words,
// blanks, quoted strings with escapes, comments and raw noise. A scanner
// model in the bench predicts the token beats of every accepted byte and the
// output side compares each beat, field by field, in order. Both sides idle
// at random, with calm stretches in between.
// ----------------------------------------------------------------------------
module quoted_token_splitter_tb;
    import qts_pkg::*;

    localparam int unsigned N_RANDOM  = 340;
    localparam int unsigned WD_LIMIT  = 500;
    localparam int unsigned DRAIN_CYC = 20;
    localparam int unsigned MAX_PRINT = 100;

    // One row of the directed table; exp is only used where typed is set
    typedef struct {
        src_beat_t              beat;
        bit                     typed;
        int                     n;
        tok_beat_t [MAX_RES-1:0] exp;
    } stim_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      src_valid = 1'b0;
    src_beat_t src       = '0;
    logic      src_stall;
    logic      tok_valid;
    logic      tok_stall = 1'b0;
    tok_beat_t tok;

    // Scanner model state and the beats it expects
    scan_state_t scan = '0;
    tok_beat_t   step_beats[$];
    tok_beat_t   tok_expected[$];

    stim_row_t dir_rows[$];
    src_beat_t src_text[$];

    int  err_cnt     = 0;
    int  idle_cycles = 0;
    int  stall_cnt   = 0;
    bit  rx_calm     = 1'b0;

    quoted_token_splitter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src       (src),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok       (tok)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------
    function automatic void put_beat(logic [7:0] ch, logic lst);
        tok_beat_t t;
        t.token_char = ch;
        t.token_last = lst;
        t.is_comment = scan.in_comment;
        step_beats = {step_beats, t};
    endfunction

    // New token character: the held one goes out, not yet marked last
    function automatic void hold_push(logic [7:0] ch);
        if (scan.held_valid)
            put_beat(scan.held_char, 1'b0);
        scan.held_char  = ch;
        scan.held_valid = 1'b1;
    endfunction

    // Token boundary: the held character goes out marked last
    function automatic void token_close();
        if (scan.held_valid)
            put_beat(scan.held_char, 1'b1);
        scan.held_valid = 1'b0;
        scan.held_char  = '0;
    endfunction

    function automatic void split_byte(src_beat_t b);
        logic       taken;
        logic [7:0] c;
        c     = b.in_char;
        taken = 1'b0;
        step_beats.delete();

        // comment swallows everything; escape resolves first
        if (scan.in_comment) begin
            hold_push(c);
            taken = 1'b1;
        end else if (scan.bs_pend) begin
            scan.bs_pend = 1'b0;
            if (c == CH_QUOTE) begin
                hold_push(CH_QUOTE);
                taken = 1'b1;
            end else begin
                hold_push(CH_BSLASH);
            end
        end

        if (!taken) begin
            if (!scan.in_string && (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})) begin
                token_close();
            end else if (scan.in_string && c == CH_BSLASH) begin
                if (b.source_last)
                    hold_push(c);
                else
                    scan.bs_pend = 1'b1;
            end else if (!scan.in_string && c == CH_HASH) begin
                token_close();
                if (!b.source_last) begin
                    scan.in_comment = 1'b1;
                    hold_push(c);
                end
            end else if (c == CH_QUOTE) begin
                scan.in_string = ~scan.in_string;
            end else begin
                hold_push(c);
            end
        end

        // final byte flushes and clears
        if (b.source_last) begin
            token_close();
            scan = '0;
        end
    endfunction

    function automatic void commit_step();
        foreach (step_beats[k])
            tok_expected = {tok_expected, step_beats[k]};
    endfunction

    // ------------------------------------------------------------------
    // Table helpers
    // ------------------------------------------------------------------
    function automatic tok_beat_t tb_beat(logic [7:0] ch, logic lst, logic cmt);
        tok_beat_t t;
        t.token_char = ch;
        t.token_last = lst;
        t.is_comment = cmt;
        return t;
    endfunction

    function automatic stim_row_t row(logic [7:0] ch, logic lst);
        stim_row_t r;
        r.beat.in_char     = ch;
        r.beat.source_last = lst;
        r.typed            = 1'b0;
        r.n                = 0;
        r.exp              = '0;
        return r;
    endfunction

    function automatic stim_row_t row_exp(logic [7:0] ch, logic lst, int n,
                                          tok_beat_t e0, tok_beat_t e1);
        stim_row_t r;
        r        = row(ch, lst);
        r.typed  = 1'b1;
        r.n      = n;
        r.exp[0] = e0;
        r.exp[1] = e1;
        return r;
    endfunction

    function automatic void add_row(stim_row_t r);
        dir_rows = {dir_rows, r};
    endfunction

    function automatic void add_ch(logic [7:0] c);
        src_beat_t b;
        b.in_char     = c;
        b.source_last = 1'b0;
        src_text = {src_text, b};
    endfunction

    // ------------------------------------------------------------------
    // Random source text: mostly well-formed pieces, some raw noise
    // ------------------------------------------------------------------
    task automatic build_source();
        int         pieces;
        int         len;
        logic [7:0] blanks[4];
        blanks = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
        src_text.delete();
        pieces = $urandom_range(1, 6);
        repeat (pieces) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    len = $urandom_range(1, 5);
                    repeat (len) add_ch(8'($urandom_range(8'h21, 8'h7E)));
                end
                3, 4: begin
                    len = $urandom_range(1, 3);
                    repeat (len) add_ch(blanks[$urandom_range(0, 3)]);
                end
                5, 6: begin
                    add_ch(CH_QUOTE);
                    len = $urandom_range(0, 5);
                    repeat (len) begin
                        case ($urandom_range(0, 5))
                            0: add_ch(blanks[$urandom_range(0, 3)]);
                            1: add_ch(CH_HASH);
                            2: begin
                                add_ch(CH_BSLASH);
                                add_ch(CH_QUOTE);
                            end
                            3: add_ch(CH_BSLASH);
                            default: add_ch(8'($urandom_range(8'h21, 8'h7E)));
                        endcase
                    end
                    // sometimes left open
                    if ($urandom_range(0, 4) != 0)
                        add_ch(CH_QUOTE);
                end
                7: begin
                    add_ch(CH_HASH);
                    len = $urandom_range(0, 6);
                    repeat (len) add_ch(8'($urandom_range(0, 255)));
                end
                8: begin
                    len = $urandom_range(1, 4);
                    repeat (len) add_ch(8'($urandom_range(0, 255)));
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0: add_ch(CH_QUOTE);
                        1: add_ch(CH_BSLASH);
                        default: add_ch(CH_HASH);
                    endcase
                end
            endcase
        end
        // most sources end with the final flag, a few run on into the next
        if ($urandom_range(0, 7) != 0)
            src_text[src_text.size()-1].source_last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------
    task automatic send_byte(src_beat_t b, int gap);
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src       <= b;
        do
            @(posedge clk);
        while (src_stall);
    endtask

    task automatic wait_drained();
        src_valid <= 1'b0;
        while (tok_expected.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Error reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        err_cnt++;
        if (err_cnt <= MAX_PRINT)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Token side: random stall, check every beat taken
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        tok_beat_t want;
        if (!rst_n)
        begin
            tok_stall <= 1'b0;
            stall_cnt = 0;
        end
        else
        begin
            if (tok_valid && !tok_stall)
            begin
                if (tok_expected.size() == 0)
                begin
                    report_mismatch("unexpected beat, token_char", tok.token_char, 0);
                end
                else
                begin
                    want = tok_expected.pop_front();
                    if (tok.token_char !== want.token_char)
                        report_mismatch("token_char", tok.token_char, want.token_char);
                    if (tok.token_last !== want.token_last)
                        report_mismatch("token_last", tok.token_last, want.token_last);
                    if (tok.is_comment !== want.is_comment)
                        report_mismatch("is_comment", tok.is_comment, want.is_comment);
                end
                stall_cnt = rx_calm ? 0 : $urandom_range(0, 10);
            end
            if (stall_cnt != 0)
            begin
                tok_stall <= 1'b1;
                stall_cnt--;
            end
            else
            begin
                tok_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no beat moving on either side
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (tok_valid && !tok_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int  sent;
        int  srcs;
        bit  tx_calm;
        stim_row_t r;

        // after reset, extremes, hash and blank as final byte
        add_row(row_exp("a", 1'b0, 0, '0, '0));
        add_row(row_exp("b", 1'b1, 2, tb_beat("a", 1'b0, 1'b0),
                        tb_beat("b", 1'b1, 1'b0)));
        add_row(row_exp(8'h00, 1'b1, 1, tb_beat(8'h00, 1'b1, 1'b0), '0));
        add_row(row_exp(8'hFF, 1'b1, 1, tb_beat(8'hFF, 1'b1, 1'b0), '0));
        add_row(row_exp(CH_HASH, 1'b1, 0, '0, '0));
        add_row(row_exp(CH_SPACE, 1'b1, 0, '0, '0));
        // string with blank, escaped quote, backslash before other byte,
        // backslash as final byte of an unterminated string
        add_row(row(CH_QUOTE, 1'b0));
        add_row(row(CH_SPACE, 1'b0));
        add_row(row(CH_BSLASH, 1'b0));
        add_row(row(CH_QUOTE, 1'b0));
        add_row(row(CH_BSLASH, 1'b0));
        add_row(row("x", 1'b0));
        add_row(row(CH_BSLASH, 1'b1));
        // tab ends a token, then a comment holding a blank and a quote
        add_row(row("k", 1'b0));
        add_row(row(CH_TAB, 1'b0));
        add_row(row(CH_HASH, 1'b0));
        add_row(row(CH_SPACE, 1'b0));
        add_row(row(CH_QUOTE, 1'b1));
        // hash right after a word, comment ending on a CR
        add_row(row("q", 1'b0));
        add_row(row(CH_HASH, 1'b0));
        add_row(row(CH_CR, 1'b1));
        // LF outside a string, then three beats from one final byte
        add_row(row(CH_LF, 1'b0));
        add_row(row(CH_QUOTE, 1'b0));
        add_row(row("m", 1'b0));
        add_row(row(CH_BSLASH, 1'b0));
        add_row(row("y", 1'b1));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            send_byte(r.beat, (i < 8) ? 0 : $urandom_range(0, 10));
            split_byte(r.beat);
            if (r.typed)
            begin
                for (int k = 0; k < r.n; k++)
                    tok_expected = {tok_expected, r.exp[k]};
            end
            else
            begin
                commit_step();
            end
        end
        wait_drained();

        // random sources
        sent = 0;
        srcs = 0;
        while (sent < N_RANDOM)
        begin
            build_source();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm <= ($urandom_range(0, 3) == 0);
            foreach (src_text[i])
            begin
                send_byte(src_text[i], tx_calm ? 0 : $urandom_range(0, 10));
                split_byte(src_text[i]);
                commit_step();
                sent++;
            end
            srcs++;
            if (srcs % 12 == 0)
                wait_drained();
        end

        // drain
        wait_drained();
        repeat (DRAIN_CYC) @(posedge clk);
        if (tok_expected.size() != 0)
            report_mismatch("beats still expected", 0, tok_expected.size());

        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
